/* rtl/brb_pkg.sv */
// Shared types and constants for the byte ring buffer with peek.
package brb_pkg;

  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 7;
  localparam int SIZE_W     = 11;
  localparam int STAT_W     = 10;
  localparam int SIZE_RESET = 1024;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_BURST = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [BYTE_W-1:0] in_byte;
    logic [CNT_W-1:0]  request_count;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              accepted;
    logic [CNT_W-1:0]  moved_count;
    logic [STAT_W-1:0] used_count;
    logic [STAT_W-1:0] free_count;
    logic              last;
  } out_item_t;

  // Decoded request as it travels from the front end to the executor.
  typedef struct packed {
    cmd_t              cmd;
    logic [BYTE_W-1:0] data;
    logic [CNT_W-1:0]  req;
  } op_t;

endpackage

/* rtl/brb_front.sv */
// Front end: accept requests, decode the command and saturate the burst length.
module brb_front #(
  parameter int MAX_BURST = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  brb_pkg::in_item_t in_data,
  output logic              op_valid,
  input  logic              op_ready,
  output brb_pkg::op_t      op
);

  logic         op_valid_r, op_valid_nxt;
  brb_pkg::op_t op_r, op_nxt;
  logic         take;

  assign in_ready = !op_valid_r || op_ready;
  assign take     = in_valid && in_ready;
  assign op_valid = op_valid_r;
  assign op       = op_r;

  always_comb begin
    op_valid_nxt = op_valid_r;
    op_nxt       = op_r;
    if (op_valid_r && op_ready) begin
      op_valid_nxt = 1'b0;
    end
    if (take) begin
      op_valid_nxt = 1'b1;
      op_nxt.cmd   = brb_pkg::cmd_t'(in_data.command);
      op_nxt.data  = in_data.in_byte;
      // clamp the burst length to the longest run supported
      if (in_data.request_count > brb_pkg::CNT_W'(MAX_BURST)) begin
        op_nxt.req = brb_pkg::CNT_W'(MAX_BURST);
      end else begin
        op_nxt.req = in_data.request_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r <= 1'b0;
    end else begin
      op_valid_r <= op_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

endmodule

/* rtl/brb_queue.sv */
// Two-entry request queue between the front end and the executor.
module brb_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  brb_pkg::op_t push_op,
  output logic         pop_valid,
  input  logic         pop_ready,
  output brb_pkg::op_t pop_op
);

  brb_pkg::op_t q_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_op     = q_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_op;
    end
  end

endmodule

/* rtl/brb_back.sv */
// Executor: ring indices, byte store, burst sequencer and result register.
module brb_back #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [brb_pkg::SIZE_W-1:0]    cfg_wdata,
  input  logic                          op_valid,
  output logic                          op_ready,
  input  brb_pkg::op_t                  op,
  output logic                          out_valid,
  input  logic                          out_ready,
  output brb_pkg::out_item_t            out_data
);

  localparam int IW  = $clog2(DEPTH);
  localparam int SZW = IW + 1;
  localparam int CW  = (SZW > brb_pkg::SIZE_W) ? SZW : brb_pkg::SIZE_W;
  localparam int XW  = (IW > brb_pkg::STAT_W) ? IW : brb_pkg::STAT_W;
  localparam int MW  = (IW > brb_pkg::CNT_W) ? IW : brb_pkg::CNT_W;
  localparam int RST_SIZE = (DEPTH < brb_pkg::SIZE_RESET) ? DEPTH : brb_pkg::SIZE_RESET;

  logic [7:0] mem [DEPTH];

  brb_pkg::state_t          state_r, state_nxt;
  logic [IW-1:0]            ridx_r, ridx_nxt;
  logic [IW-1:0]            widx_r, widx_nxt;
  logic [SZW-1:0]           size_r, size_nxt;
  logic [brb_pkg::CNT_W-1:0] rem_r, rem_nxt;
  logic                     rd_pend_r, rd_pend_nxt;
  logic                     rd_last_r, rd_last_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [IW-1:0]            rd_pos_r, rd_pos_nxt;
  logic [brb_pkg::CNT_W-1:0] moved_r, moved_nxt;
  logic [IW-1:0]            hold_used_r, hold_used_nxt;
  logic [IW-1:0]            hold_free_r, hold_free_nxt;
  brb_pkg::out_item_t       out_r, out_nxt;
  logic [7:0]               rd_data_r;

  logic                     out_free, load, issue, take;
  logic [IW-1:0]            used_c, free_c;
  logic [SZW-1:0]           w_inc, pos_inc, adv_sum;
  logic [MW-1:0]            req_x, used_m;
  logic [brb_pkg::CNT_W-1:0] n_c;
  logic [IW-1:0]            res_used, res_free;
  logic [XW-1:0]            used_x, free_x;
  logic [CW-1:0]            cfg_x;
  logic                     mem_we;

  assign out_free  = !out_valid_r || out_ready;
  assign load      = (state_r == brb_pkg::ST_BURST) && rd_pend_r && out_free;
  assign issue     = (state_r == brb_pkg::ST_BURST) && (rem_r != '0) && (!rd_pend_r || load);
  assign op_ready  = (state_r == brb_pkg::ST_IDLE) && out_free;
  assign take      = op_valid && op_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // occupancy = (write - read) mod size
  always_comb begin
    if (widx_r >= ridx_r) begin
      used_c = widx_r - ridx_r;
    end else begin
      used_c = IW'(size_r - (SZW'(ridx_r) - SZW'(widx_r)));
    end
    free_c  = IW'(size_r - SZW'(1) - SZW'(used_c));
    w_inc   = SZW'(widx_r) + SZW'(1);
    pos_inc = SZW'(rd_pos_r) + SZW'(1);
    req_x   = MW'(op.req);
    used_m  = MW'(used_c);
    n_c     = (req_x < used_m) ? op.req : brb_pkg::CNT_W'(used_c);
    adv_sum = SZW'(ridx_r) + SZW'(n_c);
    cfg_x   = CW'(cfg_wdata);
  end

  always_comb begin
    state_nxt     = state_r;
    ridx_nxt      = ridx_r;
    widx_nxt      = widx_r;
    size_nxt      = size_r;
    rem_nxt       = rem_r;
    rd_pend_nxt   = rd_pend_r;
    rd_last_nxt   = rd_last_r;
    out_valid_nxt = out_valid_r;
    rd_pos_nxt    = rd_pos_r;
    moved_nxt     = moved_r;
    hold_used_nxt = hold_used_r;
    hold_free_nxt = hold_free_r;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    res_used      = used_c;
    res_free      = free_c;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      brb_pkg::ST_IDLE: begin
        if (take) begin
          out_nxt             = '0;
          out_nxt.last        = 1'b1;
          unique case (op.cmd) inside
            brb_pkg::CMD_WRITE: begin
              if (free_c != '0) begin
                mem_we           = 1'b1;
                widx_nxt         = (w_inc == size_r) ? '0 : IW'(w_inc);
                out_nxt.accepted = 1'b1;
                res_used         = used_c + IW'(1);
                res_free         = free_c - IW'(1);
              end
              out_valid_nxt = 1'b1;
            end
            brb_pkg::CMD_CLEAR: begin
              ridx_nxt      = '0;
              widx_nxt      = '0;
              res_used      = '0;
              res_free      = IW'(size_r - SZW'(1));
              out_valid_nxt = 1'b1;
            end
            brb_pkg::CMD_READ, brb_pkg::CMD_PEEK: begin
              if (n_c == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                // set up the burst; a read moves the index right away
                state_nxt  = brb_pkg::ST_BURST;
                rd_pos_nxt = ridx_r;
                rem_nxt    = n_c;
                moved_nxt  = n_c;
                if (op.cmd == brb_pkg::CMD_READ) begin
                  ridx_nxt      = (adv_sum >= size_r) ? IW'(adv_sum - size_r) : IW'(adv_sum);
                  hold_used_nxt = used_c - IW'(n_c);
                  hold_free_nxt = free_c + IW'(n_c);
                end else begin
                  hold_used_nxt = used_c;
                  hold_free_nxt = free_c;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      brb_pkg::ST_BURST: begin
        res_used = hold_used_r;
        res_free = hold_free_r;
        if (load) begin
          out_valid_nxt       = 1'b1;
          out_nxt             = '0;
          out_nxt.out_byte    = rd_data_r;
          out_nxt.has_byte    = 1'b1;
          out_nxt.moved_count = moved_r;
          out_nxt.last        = rd_last_r;
          rd_pend_nxt         = 1'b0;
          if (rd_last_r) begin
            state_nxt = brb_pkg::ST_IDLE;
          end
        end
        if (issue) begin
          rd_pend_nxt = 1'b1;
          rd_last_nxt = (rem_r == brb_pkg::CNT_W'(1));
          rem_nxt     = rem_r - brb_pkg::CNT_W'(1);
          rd_pos_nxt  = (pos_inc == size_r) ? '0 : IW'(pos_inc);
        end
      end
      default: begin
        state_nxt = brb_pkg::ST_IDLE;
      end
    endcase

    used_x = XW'(res_used);
    free_x = XW'(res_free);
    if (take || load) begin
      out_nxt.used_count = used_x[brb_pkg::STAT_W-1:0];
      out_nxt.free_count = free_x[brb_pkg::STAT_W-1:0];
    end

    // size change empties the ring
    if (cfg_we) begin
      ridx_nxt = '0;
      widx_nxt = '0;
      if (cfg_x < CW'(2)) begin
        size_nxt = SZW'(2);
      end else if (cfg_x > CW'(DEPTH)) begin
        size_nxt = SZW'(DEPTH);
      end else begin
        size_nxt = SZW'(cfg_x);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brb_pkg::ST_IDLE;
      ridx_r      <= '0;
      widx_r      <= '0;
      size_r      <= SZW'(RST_SIZE);
      rem_r       <= '0;
      rd_pend_r   <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ridx_r      <= ridx_nxt;
      widx_r      <= widx_nxt;
      size_r      <= size_nxt;
      rem_r       <= rem_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_last_r   <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos_r    <= rd_pos_nxt;
    moved_r     <= moved_nxt;
    hold_used_r <= hold_used_nxt;
    hold_free_r <= hold_free_nxt;
    out_r       <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[widx_r] <= op.data;
    end
    if (issue) begin
      rd_data_r <= mem[rd_pos_r];
    end
  end

endmodule

/* rtl/byte_ring_buffer_with_peek.sv */
// Top level of the byte ring buffer with peek: front end, request queue and executor.
//
// Circular byte FIFO with one slot always kept empty: with buffer_size slots in
// use it holds up to buffer_size - 1 bytes. Requests carry a command: write one
// byte (dropped when full, reported by accepted), read up to request_count
// bytes (saturated to MAX_BURST and clamped to the bytes held, index advances
// with wrap), peek (same run, index stays), or clear. Write, clear and a read
// or peek that moves nothing produce one result; a read or peek of n bytes
// produces n results, the final one marked by last. Every result reports the
// used and free counts after the request. A request passes a decode register
// and a two-entry queue, so the front keeps accepting while the executor
// works. The executor finishes a write, clear or empty run when it accepts
// it; a run of n bytes is set up at the accept, then each byte goes from the
// single read port of the byte store into its registered read data and on to
// the result register, one byte per cycle while the result side does not
// stall. Writing the cfg register (clamped to 2..DEPTH) also empties the FIFO;
// write it only while no request is outstanding. The byte store needs no
// clearing after reset, so requests are taken right away.
module byte_ring_buffer_with_peek #(
  parameter int DEPTH     = 1024,
  parameter int MAX_BURST = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [brb_pkg::SIZE_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  brb_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output brb_pkg::out_item_t         out_data
);

  // decoded requests, front end to queue
  logic         f_valid, f_ready;
  brb_pkg::op_t f_op;

  // queued requests, queue to executor
  logic         q_valid, q_ready;
  brb_pkg::op_t q_op;

  brb_front #(
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .op_valid (f_valid),
    .op_ready (f_ready),
    .op       (f_op)
  );

  brb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_op    (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_op     (q_op)
  );

  brb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .op_valid  (q_valid),
    .op_ready  (q_ready),
    .op        (q_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // hold the result channel empty out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // only bytes of a run can be followed by more results of the same request
  a_run_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.has_byte && (out_data.moved_count != '0))
    else $error("non-final result without a byte");

  // a stored write never carries a byte and always closes its request
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> out_data.last && !out_data.has_byte)
    else $error("write result malformed");

  // the executor takes a queued request only while it has one
  a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready && !q_valid |=> !(out_valid && out_data.has_byte && !$past(out_valid)))
    else $error("burst started without a queued request");
`endif

endmodule

/* tb/byte_ring_buffer_with_peek_test.sv */
// Self-checking testbench for the byte ring buffer with peek: directed, random and stall tests.
module byte_ring_buffer_with_peek_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH           = 1024;
  localparam int MAX_BURST       = 64;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int NORMAL_IDLE_PCT = 27;
  localparam int HOLD_OFF_CYCLES = 300;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [brb_pkg::SIZE_W-1:0] cfg_wdata;
  logic                       in_valid;
  logic                       in_ready;
  brb_pkg::in_item_t          in_data;
  logic                       out_valid;
  logic                       out_ready;
  brb_pkg::out_item_t         out_data;

  // Shadow copy of the FIFO: byte store, both indices and the slot count in use.
  logic [brb_pkg::BYTE_W-1:0] shadow_mem [DEPTH];
  int unsigned                head_idx;
  int unsigned                tail_idx;
  int unsigned                ring_slots;

  // Results still owed by the block, oldest first.
  brb_pkg::out_item_t         expected_results [$];

  int error_count     = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int size_writes     = 0;
  int cycle_count     = 0;

  // Idle and stall controls; the tests retune these between phases.
  int send_idle_pct   = NORMAL_IDLE_PCT;
  int recv_stall_pct  = NORMAL_IDLE_PCT;

  // Long receiver hold-off, started by a test and timed by its own process.
  event hold_off_start;
  bit   holding_off;

  byte_ring_buffer_with_peek #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Bytes held, with one slot always left empty.
  function automatic int unsigned bytes_held();
    if (head_idx > tail_idx) begin
      return ring_slots - (head_idx - tail_idx);
    end
    return tail_idx - head_idx;
  endfunction

  // Result with no byte: used and free counts as they stand now, last set.
  function automatic brb_pkg::out_item_t status_result(input logic stored);
    brb_pkg::out_item_t r;
    r             = '0;
    r.accepted    = stored;
    r.used_count  = brb_pkg::STAT_W'(bytes_held());
    r.free_count  = brb_pkg::STAT_W'(ring_slots - 1 - bytes_held());
    r.last        = 1'b1;
    return r;
  endfunction

  // Work out every result one request causes and advance the shadow FIFO.
  function automatic void predict_request(input brb_pkg::in_item_t req);
    int unsigned        n;
    int unsigned        pos;
    brb_pkg::out_item_t r;
    case (brb_pkg::cmd_t'(req.command))
      brb_pkg::CMD_WRITE: begin
        if (ring_slots - 1 - bytes_held() > 0) begin
          shadow_mem[tail_idx] = req.in_byte;
          tail_idx = (tail_idx + 1) % ring_slots;
          expected_results.push_back(status_result(1'b1));
        end else begin
          // Drop the byte when full.
          expected_results.push_back(status_result(1'b0));
        end
      end
      brb_pkg::CMD_CLEAR: begin
        head_idx = 0;
        tail_idx = 0;
        expected_results.push_back(status_result(1'b0));
      end
      default: begin
        // Saturate the request to the burst limit, then clamp to what is held.
        n = 32'(req.request_count);
        if (n > MAX_BURST) n = MAX_BURST;
        if (n > bytes_held()) n = bytes_held();
        if (n == 0) begin
          expected_results.push_back(status_result(1'b0));
        end else begin
          pos = head_idx;
          // A read moves the index before the counts are reported; a peek holds it.
          if (req.command == brb_pkg::CMD_READ) head_idx = (head_idx + n) % ring_slots;
          for (int i = 0; i < n; i++) begin
            r             = status_result(1'b0);
            r.out_byte    = shadow_mem[pos];
            r.has_byte    = 1'b1;
            r.moved_count = brb_pkg::CNT_W'(n);
            r.last        = (i == n - 1);
            expected_results.push_back(r);
            pos = (pos + 1) % ring_slots;
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready generation and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Time a long hold-off each time one is requested.
  initial begin : hold_off_counter
    holding_off = 1'b0;
    forever begin
      @(hold_off_start);
      holding_off = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      holding_off = 1'b0;
    end
  end

  // Hold ready low during a hold-off, else stall at random.
  always @(posedge clk) begin
    if (holding_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin : check_result
    brb_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected", 1, 0);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_data.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_data.out_byte, want.out_byte);
        if (out_data.has_byte !== want.has_byte)
          report_mismatch("has_byte", out_data.has_byte, want.has_byte);
        if (out_data.accepted !== want.accepted)
          report_mismatch("accepted", out_data.accepted, want.accepted);
        if (out_data.moved_count !== want.moved_count)
          report_mismatch("moved_count", out_data.moved_count, want.moved_count);
        if (out_data.used_count !== want.used_count)
          report_mismatch("used_count", out_data.used_count, want.used_count);
        if (out_data.free_count !== want.free_count)
          report_mismatch("free_count", out_data.free_count, want.free_count);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request after a random idle gap, hold it until accepted, then predict.
  // Valid is left high on acceptance so back-to-back requests need no gap.
  task automatic send_request(input brb_pkg::cmd_t cmd,
                              input logic [brb_pkg::BYTE_W-1:0] data,
                              input logic [brb_pkg::CNT_W-1:0] count);
    brb_pkg::in_item_t item;
    item.command       = cmd;
    item.in_byte       = data;
    item.request_count = count;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predict_request(item);
    requests_sent++;
  endtask

  // Drop valid and wait until every owed result has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Write the size register while idle; the write also empties the FIFO.
  task automatic write_buffer_size(input int value);
    int unsigned slots;
    wait_for_results();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[brb_pkg::SIZE_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    // Clamp to the range the store supports.
    slots = value & ((1 << brb_pkg::SIZE_W) - 1);
    if (slots < 2) slots = 2;
    if (slots > DEPTH) slots = DEPTH;
    ring_slots = slots;
    head_idx   = 0;
    tail_idx   = 0;
    size_writes++;
    @(posedge clk);
  endtask

  // Request count biased toward short runs, with some above the burst limit.
  function automatic logic [brb_pkg::CNT_W-1:0] random_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return brb_pkg::CNT_W'($urandom_range(8));
    if (pick < 88) return brb_pkg::CNT_W'($urandom_range(MAX_BURST));
    return brb_pkg::CNT_W'($urandom_range((1 << brb_pkg::CNT_W) - 1, MAX_BURST - 1));
  endfunction

  task automatic run_random_requests(input int n_items, input int write_pct);
    int            roll;
    brb_pkg::cmd_t cmd;
    repeat (n_items) begin
      roll = $urandom_range(99);
      if (roll < write_pct) cmd = brb_pkg::CMD_WRITE;
      else if (roll < 97) cmd = ($urandom_range(1) != 0) ? brb_pkg::CMD_READ : brb_pkg::CMD_PEEK;
      else cmd = brb_pkg::CMD_CLEAR;
      send_request(cmd, brb_pkg::BYTE_W'($urandom_range(255)), random_count());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes of the fields, every command, and the corner cases of the ring.
  task automatic test_directed_cases();
    // Empty FIFO at the reset size: read and peek of nothing.
    send_request(brb_pkg::CMD_READ,  8'h00, 7'd0);
    send_request(brb_pkg::CMD_PEEK,  8'hFF, 7'd5);
    send_request(brb_pkg::CMD_WRITE, 8'h00, 7'd0);
    send_request(brb_pkg::CMD_WRITE, 8'hFF, 7'h7F);
    send_request(brb_pkg::CMD_WRITE, 8'h5A, 7'd0);
    // Zero request on a non-empty FIFO, then an oversized one.
    send_request(brb_pkg::CMD_PEEK,  8'h00, 7'd0);
    send_request(brb_pkg::CMD_PEEK,  8'h00, 7'h7F);
    send_request(brb_pkg::CMD_READ,  8'h00, 7'd2);
    send_request(brb_pkg::CMD_WRITE, 8'hA5, 7'd0);
    send_request(brb_pkg::CMD_CLEAR, 8'hFF, 7'h7F);
    send_request(brb_pkg::CMD_READ,  8'h00, 7'd64);
    // Smallest ring: capacity of one byte, drop on full, wrap of both indices.
    write_buffer_size(2);
    send_request(brb_pkg::CMD_WRITE, 8'h11, 7'd0);
    send_request(brb_pkg::CMD_WRITE, 8'h22, 7'd0);
    send_request(brb_pkg::CMD_PEEK,  8'h00, 7'd1);
    send_request(brb_pkg::CMD_READ,  8'h00, 7'd1);
    send_request(brb_pkg::CMD_WRITE, 8'h33, 7'd0);
    send_request(brb_pkg::CMD_READ,  8'h00, 7'h7F);
    // Four slots: fill, drop, then a peek run that wraps.
    write_buffer_size(4);
    for (int i = 0; i < 4; i++) begin
      send_request(brb_pkg::CMD_WRITE, brb_pkg::BYTE_W'(8'h40 + i), 7'd0);
    end
    send_request(brb_pkg::CMD_READ,  8'h00, 7'd2);
    send_request(brb_pkg::CMD_WRITE, 8'hC3, 7'd0);
    send_request(brb_pkg::CMD_WRITE, 8'h3C, 7'd0);
    send_request(brb_pkg::CMD_PEEK,  8'h00, 7'd64);
  endtask

  // Random commands over several ring sizes, out-of-range size values included.
  task automatic test_random_mix();
    write_buffer_size(5);
    run_random_requests(50, 60);
    write_buffer_size(17);
    run_random_requests(50, 70);
    // A size of one acts as two.
    write_buffer_size(1);
    run_random_requests(30, 50);
    write_buffer_size(64);
    run_random_requests(60, 80);
    // An oversized value acts as the full store.
    write_buffer_size((1 << brb_pkg::SIZE_W) - 1);
    run_random_requests(40, 60);
    write_buffer_size($urandom_range(40, 3));
    run_random_requests(40, 65);
  endtask

  // Full rate on both sides: no idle cycle at all for a stretch.
  task automatic test_no_idle_stretch();
    write_buffer_size(33);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_requests(40, 60);
    wait_for_results();
    send_idle_pct  = NORMAL_IDLE_PCT;
    recv_stall_pct = NORMAL_IDLE_PCT;
  endtask

  // Hold the result side off long enough that the block fills and stalls its input,
  // while the sender keeps offering; then pause the sender until all results are in.
  task automatic test_output_backpressure();
    write_buffer_size(1024);
    send_idle_pct = 0;
    -> hold_off_start;
    for (int i = 0; i < 16; i++) begin
      send_request(brb_pkg::CMD_WRITE, brb_pkg::BYTE_W'($urandom_range(255)), 7'd0);
    end
    for (int i = 0; i < 4; i++) send_request(brb_pkg::CMD_PEEK, 8'h00, 7'd8);
    for (int i = 0; i < 4; i++) send_request(brb_pkg::CMD_READ, 8'h00, 7'd4);
    for (int i = 0; i < 6; i++) begin
      send_request(brb_pkg::CMD_WRITE, brb_pkg::BYTE_W'($urandom_range(255)), 7'd0);
    end
    wait_for_results();
    send_idle_pct = NORMAL_IDLE_PCT;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    ring_slots  = brb_pkg::SIZE_RESET;
    head_idx    = 0;
    tail_idx    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_mix();
    test_no_idle_stretch();
    test_output_backpressure();

    // Drain, then let the pipeline run on to show any stray result.
    wait_for_results();
    repeat (12) @(posedge clk);

    $display("Ran %0d requests over %0d size settings; %0d results checked in %0d cycles.",
             requests_sent, size_writes, results_checked, cycle_count);
    $display("Covered empty, full, wrapped, saturated and zero-length runs under stalls.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles with %0d results owed",
             cycle_count, expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
